// File: hdl/scrlc_pkg.sv
// Package for the serial command relay and lamp controller.
// Holds lamp codes, frame characters, register indexes and the result struct.
// No dependencies.
package scrlc_pkg;

   // Lamp bit positions within a 4-bit lamp word
   localparam int unsigned LAMP_RELAY_BIT = 3;
   localparam int unsigned LAMP_GREEN_BIT = 2;
   localparam int unsigned LAMP_BLUE_BIT  = 1;
   localparam int unsigned LAMP_RED_BIT   = 0;

   localparam logic [3:0] LAMPS_NONE  = 4'b0000;
   localparam logic [3:0] LAMPS_RELAY = 4'b1000;
   localparam logic [3:0] LAMPS_GREEN = 4'b0100;
   localparam logic [3:0] LAMPS_BLUE  = 4'b0010;
   localparam logic [3:0] LAMPS_RED   = 4'b0001;

   // Frame characters
   localparam logic [7:0] CHAR_START     = 8'h23; // '#'
   localparam logic [7:0] CHAR_AMP       = 8'h26; // '&'
   localparam logic [7:0] CHAR_END       = 8'h2A; // '*'
   localparam logic [7:0] CHAR_BROADCAST = 8'h5A; // 'Z'

   // Function codes
   localparam logic [7:0] FUNC_OFF       = 8'h30; // '0'
   localparam logic [7:0] FUNC_ON        = 8'h31; // '1'
   localparam logic [7:0] FUNC_TEST      = 8'h32; // '2'
   localparam logic [7:0] FUNC_ALARM_OFF = 8'h33; // '3'
   localparam logic [7:0] FUNC_ALARM_ON  = 8'h34; // '4'

   // Register reset values
   localparam logic [7:0]  MODULE_ID_RESET   = 8'd54;   // '6'
   localparam logic [15:0] STAGE_TICKS_RESET = 16'd5000;

   // Register indexes (word address bit 2)
   localparam logic REG_MODULE_ID   = 1'b0;
   localparam logic REG_STAGE_TICKS = 1'b1;

   localparam int unsigned TEST_STAGES_DEFAULT = 6;
   localparam int unsigned STAGE_BITS          = 3;

   typedef struct packed {
      logic relay_on;
      logic green_on;
      logic blue_on;
      logic red_on;
      logic test_busy;
   } result_type;

   // Lamp word for each lamp test stage
   function automatic logic [3:0] test_pattern(input logic [STAGE_BITS-1:0] stage);
      logic [3:0] lamps;
      case (stage)
         3'd1:    lamps = LAMPS_RED;
         3'd2:    lamps = LAMPS_GREEN;
         3'd3:    lamps = LAMPS_BLUE;
         3'd4:    lamps = LAMPS_RELAY;
         default: lamps = LAMPS_NONE;
      endcase
      return lamps;
   endfunction

   // Lamp word that a load mode selects
   function automatic logic [3:0] mode_lamps(input logic mode);
      return mode ? (LAMPS_RELAY | LAMPS_GREEN) : LAMPS_RED;
   endfunction

endpackage

// File: hdl/serial_command_relay_led_controller.sv
// Top level of the serial command relay and lamp controller.
// Holds the configuration registers and joins the engine to the output buffer.
// Depends on scrlc_pkg, scrlc_engine and scrlc_out_buf.

// Each transaction on the req_ channel is one event: a received serial byte
// (req_action 0) or a one-millisecond tick (req_action 1). Every transaction
// yields exactly one result on the rsp_ channel showing the relay and lamp
// levels and the lamp test flag after that event. The block takes one
// transaction per clock cycle: the whole state update is a single short pass
// of logic from the accepted transaction into the result registers, and
// results leave through a two-entry output buffer, so req_stall rises only
// once two results are waiting behind a stalled rsp_ side. module_id (address
// 0) and stage_ticks (address 4) are written through the csr_ port; the user
// must write them only while the block is idle; the block does not enforce it.
module serial_command_relay_led_controller #(
   parameter int unsigned TEST_STAGES = scrlc_pkg::TEST_STAGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_relay_on,
   output logic        rsp_green_on,
   output logic        rsp_blue_on,
   output logic        rsp_red_on,
   output logic        rsp_test_busy,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]             module_id_ff, module_id_in;
   logic [15:0]            stage_ticks_ff, stage_ticks_in;
   logic                   csr_write;
   logic                   req_accept;
   logic                   buf_full;
   scrlc_pkg::result_type  step_result;
   scrlc_pkg::result_type  rsp_data;

   // Configuration registers: decode on the word address bit, ignore byte offset
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      module_id_in   = module_id_ff;
      stage_ticks_in = stage_ticks_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            scrlc_pkg::REG_MODULE_ID:   module_id_in   = csr_pwdata[7:0];
            scrlc_pkg::REG_STAGE_TICKS: stage_ticks_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         scrlc_pkg::REG_MODULE_ID:   csr_prdata = {24'd0, module_id_ff};
         scrlc_pkg::REG_STAGE_TICKS: csr_prdata = {16'd0, stage_ticks_ff};
         default:                    csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         module_id_ff   <= scrlc_pkg::MODULE_ID_RESET;
         stage_ticks_ff <= scrlc_pkg::STAGE_TICKS_RESET;
      end else begin
         module_id_ff   <= module_id_in;
         stage_ticks_ff <= stage_ticks_in;
      end
   end

   // Hold off new transactions only while both buffer entries are taken
   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   scrlc_engine #(
      .TEST_STAGES (TEST_STAGES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_accept),
      .action      (req_action),
      .rx_byte     (req_rx_byte),
      .module_id   (module_id_ff),
      .stage_ticks (stage_ticks_ff),
      .result      (step_result)
   );

   scrlc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_result),
      .out_stall (rsp_stall),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   assign rsp_relay_on  = rsp_data.relay_on;
   assign rsp_green_on  = rsp_data.green_on;
   assign rsp_blue_on   = rsp_data.blue_on;
   assign rsp_red_on    = rsp_data.red_on;
   assign rsp_test_busy = rsp_data.test_busy;

endmodule

// File: hdl/scrlc_engine.sv
// Frame parser, function decoder and lamp test sequencer.
// Updates its state on each accepted transaction and presents the state after it.
// Depends on scrlc_pkg.
module scrlc_engine #(
   parameter int unsigned TEST_STAGES = scrlc_pkg::TEST_STAGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  logic                   action,
   input  logic [7:0]             rx_byte,
   input  logic [7:0]             module_id,
   input  logic [15:0]            stage_ticks,
   output scrlc_pkg::result_type  result
);

   typedef enum logic [4:0] {
      PH_START = 5'b00001,
      PH_ID    = 5'b00010,
      PH_AMP   = 5'b00100,
      PH_CODE  = 5'b01000,
      PH_TAIL  = 5'b10000
   } phase_type;

   localparam int unsigned SB = scrlc_pkg::STAGE_BITS;
   localparam logic [SB:0] STAGE_LIMIT = (SB+1)'(TEST_STAGES);

   phase_type         phase_ff, phase_in;
   logic [7:0]        code_ff, code_in;
   logic              code_valid_ff, code_valid_in;
   logic              mode_ff, mode_in;
   logic [3:0]        lamps_ff, lamps_in;
   logic [SB-1:0]     stage_ff, stage_in;
   logic [15:0]       tick_ff, tick_in;
   logic              running_ff, running_in;

   logic [15:0]       limit;
   logic [15:0]       tick_next;
   logic [SB-1:0]     stage_next;

   assign limit      = (stage_ticks == 16'd0) ? 16'd1 : stage_ticks;
   assign tick_next  = tick_ff + 16'd1;
   assign stage_next = stage_ff + SB'(1);

   always_comb begin
      phase_in      = phase_ff;
      code_in       = code_ff;
      code_valid_in = code_valid_ff;
      mode_in       = mode_ff;
      lamps_in      = lamps_ff;
      stage_in      = stage_ff;
      tick_in       = tick_ff;
      running_in    = running_ff;
      if (item_valid) begin
         if (!action) begin
            // drop bytes while the lamp test runs
            if (!running_ff) begin
               unique case (phase_ff)
                  PH_START: begin
                     if (rx_byte == scrlc_pkg::CHAR_START) phase_in = PH_ID;
                  end
                  PH_ID: begin
                     phase_in = (rx_byte == module_id || rx_byte == scrlc_pkg::CHAR_BROADCAST)
                                ? PH_AMP : PH_TAIL;
                  end
                  PH_AMP: begin
                     phase_in = (rx_byte == scrlc_pkg::CHAR_AMP) ? PH_CODE : PH_TAIL;
                  end
                  PH_CODE: begin
                     code_in       = rx_byte;
                     code_valid_in = 1'b1;
                     phase_in      = PH_TAIL;
                  end
                  PH_TAIL: begin
                     if (rx_byte == scrlc_pkg::CHAR_END) begin
                        phase_in      = PH_START;
                        code_in       = 8'd0;
                        code_valid_in = 1'b0;
                        if (code_valid_ff) begin
                           unique case (code_ff)
                              scrlc_pkg::FUNC_OFF: begin
                                 mode_in  = 1'b0;
                                 lamps_in = scrlc_pkg::mode_lamps(1'b0);
                              end
                              scrlc_pkg::FUNC_ON: begin
                                 mode_in  = 1'b1;
                                 lamps_in = scrlc_pkg::mode_lamps(1'b1);
                              end
                              scrlc_pkg::FUNC_TEST: begin
                                 running_in = 1'b1;
                                 stage_in   = '0;
                                 tick_in    = 16'd0;
                                 lamps_in   = scrlc_pkg::test_pattern('0);
                              end
                              scrlc_pkg::FUNC_ALARM_OFF: begin
                                 lamps_in = scrlc_pkg::mode_lamps(mode_ff);
                              end
                              scrlc_pkg::FUNC_ALARM_ON: begin
                                 lamps_in = (lamps_ff & scrlc_pkg::LAMPS_RED)
                                            | scrlc_pkg::LAMPS_BLUE;
                              end
                              default: ;
                           endcase
                        end
                     end
                  end
                  default: phase_in = PH_START;
               endcase
            end
         end else if (running_ff) begin
            tick_in = tick_next;
            if (tick_next >= limit) begin
               tick_in = 16'd0;
               if (({1'b0, stage_next} >= STAGE_LIMIT) || (stage_next == '0)) begin
                  running_in = 1'b0;
                  stage_in   = '0;
                  lamps_in   = scrlc_pkg::mode_lamps(mode_ff);
               end else begin
                  stage_in = stage_next;
                  lamps_in = scrlc_pkg::test_pattern(stage_next);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         code_ff       <= 8'd0;
         code_valid_ff <= 1'b0;
         mode_ff       <= 1'b0;
         lamps_ff      <= scrlc_pkg::LAMPS_RED;
         stage_ff      <= '0;
         tick_ff       <= 16'd0;
         running_ff    <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         code_ff       <= code_in;
         code_valid_ff <= code_valid_in;
         mode_ff       <= mode_in;
         lamps_ff      <= lamps_in;
         stage_ff      <= stage_in;
         tick_ff       <= tick_in;
         running_ff    <= running_in;
      end
   end

   assign result.relay_on  = lamps_in[scrlc_pkg::LAMP_RELAY_BIT];
   assign result.green_on  = lamps_in[scrlc_pkg::LAMP_GREEN_BIT];
   assign result.blue_on   = lamps_in[scrlc_pkg::LAMP_BLUE_BIT];
   assign result.red_on    = lamps_in[scrlc_pkg::LAMP_RED_BIT];
   assign result.test_busy = running_in;

endmodule

// File: hdl/scrlc_out_buf.sv
// Two-entry output buffer: output register plus skid register.
// Lets the input side keep going while one result waits. Depends on scrlc_pkg.
module scrlc_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  scrlc_pkg::result_type  push_data,
   input  logic                   out_stall,
   output logic                   full,
   output logic                   out_valid,
   output scrlc_pkg::result_type  out_data
);

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   scrlc_pkg::result_type  out_data_ff, out_data_in;
   scrlc_pkg::result_type  skid_data_ff, skid_data_in;
   logic                   pop;

   assign pop = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// File: hdl/scrlc_checker.sv
// Port-level checker for the serial command relay and lamp controller.
// Bound to the top level; depends on nothing else.
module scrlc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_relay_on,
   input logic        rsp_green_on,
   input logic        rsp_blue_on,
   input logic        rsp_red_on,
   input logic        rsp_test_busy
);

   // Input back-pressure only once a result is already waiting
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending result");

   // During the lamp test at most one lamp or the relay is driven
   a_test_single_lamp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_test_busy)
         |-> $onehot0({rsp_relay_on, rsp_green_on, rsp_blue_on, rsp_red_on}))
      else $error("more than one output driven during lamp test");

   // Outside the test, relay and green always move together
   a_relay_green_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_test_busy) |-> (rsp_relay_on == rsp_green_on))
      else $error("relay and green differ outside lamp test");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable({rsp_relay_on, rsp_green_on,
                                     rsp_blue_on, rsp_red_on, rsp_test_busy})))
      else $error("stalled result changed");

endmodule

bind serial_command_relay_led_controller scrlc_checker u_scrlc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_relay_on  (rsp_relay_on),
   .rsp_green_on  (rsp_green_on),
   .rsp_blue_on   (rsp_blue_on),
   .rsp_red_on    (rsp_red_on),
   .rsp_test_busy (rsp_test_busy)
);

// File: dv/scrlc_relay_checker.sv
// Checker for the serial command relay and lamp controller.
// Watches the req_, rsp_ and csr_ traffic, predicts every result and compares.
// Depends on scrlc_pkg.
module scrlc_relay_checker #(
   parameter int unsigned STAGES = scrlc_pkg::TEST_STAGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_relay_on,
   input  logic        rsp_green_on,
   input  logic        rsp_blue_on,
   input  logic        rsp_red_on,
   input  logic        rsp_test_busy,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          failures,
   output int          outstanding,
   output int          results_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import scrlc_pkg::*;

   typedef enum logic [2:0] {
      SEEK_START,
      SEEK_ID,
      SEEK_AMP,
      SEEK_CODE,
      SKIP_TAIL
   } frame_phase_e;

   // predicted controller state and register copies
   frame_phase_e phase;
   logic [7:0]   unit_id;
   logic [15:0]  stage_len;
   logic [7:0]   held_code;
   logic         held_code_valid;
   logic         mode_on;
   logic [3:0]   lamps;
   logic [2:0]   stage;
   logic [15:0]  tick_total;
   logic         testing;

   result_type   expected_levels[$];

   initial begin
      failures        = 0;
      outstanding     = 0;
      results_checked = 0;
   end

   function automatic logic [3:0] load_lamps();
      return mode_on ? (LAMPS_RELAY | LAMPS_GREEN) : LAMPS_RED;
   endfunction

   task automatic log_mismatch(input string what);
      failures++;
      if (failures <= 60)
         $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Advance the predicted state by one event
   function automatic void advance_controller(input logic tick, input logic [7:0] b);
      logic [15:0] limit;
      logic [7:0]  code;
      logic        run_code;
      run_code = 1'b0;
      code     = 8'h00;
      if (!tick) begin
         if (!testing) begin
            case (phase)
               SEEK_START: if (b == CHAR_START) phase = SEEK_ID;
               SEEK_ID:    phase = (b == unit_id || b == CHAR_BROADCAST) ? SEEK_AMP : SKIP_TAIL;
               SEEK_AMP:   phase = (b == CHAR_AMP) ? SEEK_CODE : SKIP_TAIL;
               SEEK_CODE: begin
                  held_code       = b;
                  held_code_valid = 1'b1;
                  phase           = SKIP_TAIL;
               end
               default: begin
                  if (b == CHAR_END) begin
                     run_code        = held_code_valid;
                     code            = held_code;
                     held_code_valid = 1'b0;
                     held_code       = 8'h00;
                     phase           = SEEK_START;
                  end
               end
            endcase
         end
      end else if (testing) begin
         limit      = (stage_len == 16'd0) ? 16'd1 : stage_len;
         tick_total = tick_total + 16'd1;
         if (tick_total >= limit) begin
            tick_total = 16'd0;
            stage      = stage + 3'd1;
            if (stage >= STAGES || stage == 3'd0) begin
               testing = 1'b0;
               stage   = 3'd0;
               lamps   = load_lamps();
            end else begin
               case (stage)
                  3'd1:    lamps = LAMPS_RED;
                  3'd2:    lamps = LAMPS_GREEN;
                  3'd3:    lamps = LAMPS_BLUE;
                  3'd4:    lamps = LAMPS_RELAY;
                  default: lamps = LAMPS_NONE;
               endcase
            end
         end
      end
      if (run_code) begin
         case (code)
            FUNC_OFF: begin
               mode_on = 1'b0;
               lamps   = load_lamps();
            end
            FUNC_ON: begin
               mode_on = 1'b1;
               lamps   = load_lamps();
            end
            FUNC_TEST: begin
               testing    = 1'b1;
               stage      = 3'd0;
               tick_total = 16'd0;
               lamps      = LAMPS_NONE;
            end
            FUNC_ALARM_OFF: lamps = load_lamps();
            FUNC_ALARM_ON:  lamps = (lamps & LAMPS_RED) | LAMPS_BLUE;
            default: ;
         endcase
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type seen;
      result_type want;
      if (reset) begin
         phase           = SEEK_START;
         unit_id         = MODULE_ID_RESET;
         stage_len       = STAGE_TICKS_RESET;
         held_code       = 8'h00;
         held_code_valid = 1'b0;
         mode_on         = 1'b0;
         lamps           = LAMPS_RED;
         stage           = 3'd0;
         tick_total      = 16'd0;
         testing         = 1'b0;
         expected_levels.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2])
               REG_MODULE_ID:   unit_id   = csr_pwdata[7:0];
               REG_STAGE_TICKS: stage_len = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_controller(req_action, req_rx_byte);
            expected_levels.push_back({lamps[LAMP_RELAY_BIT], lamps[LAMP_GREEN_BIT],
                                       lamps[LAMP_BLUE_BIT], lamps[LAMP_RED_BIT], testing});
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_relay_on, rsp_green_on, rsp_blue_on, rsp_red_on, rsp_test_busy};
            if (expected_levels.size() == 0) begin
               log_mismatch($sformatf("result %b arrived with nothing expected", seen));
            end else begin
               want = expected_levels.pop_front();
               results_checked++;
               if (seen !== want)
                  log_mismatch($sformatf(
                     "relay %b/%b green %b/%b blue %b/%b red %b/%b busy %b/%b (got/exp)",
                     seen.relay_on, want.relay_on, seen.green_on, want.green_on,
                     seen.blue_on, want.blue_on, seen.red_on, want.red_on,
                     seen.test_busy, want.test_busy));
            end
         end
      end
      outstanding = expected_levels.size();
   end

endmodule

// File: dv/tb_serial_command_relay_led_controller.sv
// Testbench top for the serial command relay and lamp controller.
// Generates byte and tick traffic, register writes and back-pressure; gives the verdict.
// Depends on scrlc_pkg, serial_command_relay_led_controller and scrlc_relay_checker.
module tb_serial_command_relay_led_controller;
   timeunit 1ns;
   timeprecision 1ps;
   import scrlc_pkg::*;

   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 150;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_relay_on;
   logic        rsp_green_on;
   logic        rsp_blue_on;
   logic        rsp_red_on;
   logic        rsp_test_busy;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          failures;
   int          outstanding;
   int          results_checked;

   // stimulus bookkeeping: what the driver has programmed, not a prediction
   logic [7:0]  unit_id    = MODULE_ID_RESET;
   logic [15:0] unit_ticks = STAGE_TICKS_RESET;
   bit          sender_gaps = 1'b0;
   logic        rsp_gaps    = 1'b0;
   int          rsp_hold    = 0;
   int          items_sent  = 0;

   serial_command_relay_led_controller uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_relay_on  (rsp_relay_on),
      .rsp_green_on  (rsp_green_on),
      .rsp_blue_on   (rsp_blue_on),
      .rsp_red_on    (rsp_red_on),
      .rsp_test_busy (rsp_test_busy),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   scrlc_relay_checker relay_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_relay_on    (rsp_relay_on),
      .rsp_green_on    (rsp_green_on),
      .rsp_blue_on     (rsp_blue_on),
      .rsp_red_on      (rsp_red_on),
      .rsp_test_busy   (rsp_test_busy),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_pready      (csr_pready),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Generous guard: the slowest legal run needs a small fraction of this.
   initial begin
      #(20_000_000);
      $display("** serial_command_relay_led_controller: FAILED **");
      $finish;
   end

   // Result-side back-pressure. Alternate free stretches with stall bursts, each
   // of random length; hold stall low whenever back-pressure is off.
   always @(posedge clock) begin
      if (reset || !rsp_gaps) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= $urandom_range(0, 30);
      end else begin
         rsp_stall <= 1'b1;
         rsp_hold  <= $urandom_range(0, 16);
      end
   end

   // Offer one transaction and hold it until the block takes it. The stall is
   // sampled on the falling edge, so acceptance never hinges on event order at
   // the rising edge. Valid is left high on return: the next call either keeps
   // it high with a new payload or drops it for a gap.
   task automatic push_event(input logic tick, input logic [7:0] data);
      int   gap;
      logic stalled;
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_action  <= tick;
      req_rx_byte <= data;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         push_event(1'b0, s[i]);
   endtask

   task automatic send_ticks(input int count);
      for (int i = 0; i < count; i++)
         push_event(1'b1, 8'($urandom_range(0, 255)));
   endtask

   // Mostly frame characters and function codes, so that a '*' or '#' turns up
   // in every position of a frame; otherwise any byte at all.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0:       return CHAR_START;
         1:       return CHAR_AMP;
         2:       return CHAR_END;
         3:       return CHAR_BROADCAST;
         4:       return FUNC_OFF + 8'($urandom_range(0, 4));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Send one frame byte, now and then preceded by a stray tick.
   task automatic frame_byte(input logic [7:0] b);
      if ($urandom_range(0, 11) == 0)
         push_event(1'b1, 8'($urandom_range(0, 255)));
      push_event(1'b0, b);
   endtask

   // Stop offering transactions and wait until every result has come back,
   // then let the pipeline settle.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (2) @(posedge clock);
   endtask

   // Setup cycle then access cycle; the register lands on the edge with pready.
   task automatic write_register(input logic idx, input logic [31:0] value);
      logic ready;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         ready = csr_pready;
         @(posedge clock);
      end while (!ready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_MODULE_ID)
         unit_id = value[7:0];
      else
         unit_ticks = value[15:0];
   endtask

   // One frame with random content. Usually well formed and addressed to this
   // unit or to broadcast; after a lamp test request, feed enough ticks to walk
   // every stage, with bytes mixed in that the block must drop.
   task automatic send_random_frame(input bit tests_allowed);
      logic [7:0] id_byte;
      logic [7:0] amp_byte;
      logic [7:0] code_byte;
      int         roll;
      int         ticks_left;
      roll = $urandom_range(0, 99);
      id_byte  = (roll < 55) ? unit_id : ((roll < 80) ? CHAR_BROADCAST : pick_byte());
      amp_byte = ($urandom_range(0, 99) < 85) ? CHAR_AMP : pick_byte();
      code_byte = ($urandom_range(0, 99) < 85) ? FUNC_OFF + 8'($urandom_range(0, 4))
                                                : pick_byte();
      if (!tests_allowed && code_byte == FUNC_TEST)
         code_byte = FUNC_ALARM_ON;
      frame_byte(CHAR_START);
      frame_byte(id_byte);
      frame_byte(amp_byte);
      frame_byte(code_byte);
      repeat ($urandom_range(0, 2)) frame_byte(pick_byte());
      frame_byte(CHAR_END);
      if (code_byte == FUNC_TEST && amp_byte == CHAR_AMP &&
          (id_byte == unit_id || id_byte == CHAR_BROADCAST)) begin
         ticks_left = TEST_STAGES_DEFAULT * ((unit_ticks == 16'd0) ? 1 : int'(unit_ticks))
                      + $urandom_range(0, 2);
         while (ticks_left > 0) begin
            if ($urandom_range(0, 4) == 0) begin
               push_event(1'b0, pick_byte());
            end else begin
               push_event(1'b1, 8'($urandom_range(0, 255)));
               ticks_left--;
            end
         end
      end
   endtask

   initial begin
      int         target;
      bit         tests_allowed;
      logic [7:0] next_id;
      logic [15:0] next_ticks;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_action  <= 1'b0;
      req_rx_byte <= 8'h00;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= 3'd0;
      csr_pwdata  <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part, at reset register values ('6', 5000 ticks per stage).
      push_event(1'b1, 8'hFF);          // tick with no test running: ignored
      send_text("#6&1*");               // load on: relay and green
      send_text("#Z&4*");               // alarm on by broadcast: blue, red kept
      send_text("#Z&2*");               // lamp test at the long reset stage length
      push_event(1'b1, 8'h00);
      push_event(1'b1, 8'h00);
      push_event(1'b0, 8'hFF);          // bytes during the test are dropped
      push_event(1'b0, CHAR_START);
      // Shorten the stage mid-test; zero must behave as one tick per stage.
      wait_for_results();
      write_register(REG_STAGE_TICKS, 32'd0);
      send_ticks(TEST_STAGES_DEFAULT);

      // Random part: a run of phases, each with its own register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin next_id = 8'd0;            next_ticks = 16'd1;     end
            1: begin next_id = 8'd255;          next_ticks = 16'd2;     end
            2: begin next_id = CHAR_BROADCAST;  next_ticks = 16'd3;     end
            3: begin next_id = MODULE_ID_RESET; next_ticks = 16'hFFFF;  end
            default: begin
               next_id    = 8'($urandom_range(0, 255));
               next_ticks = 16'($urandom_range(1, 4));
            end
         endcase
         wait_for_results();
         write_register(REG_MODULE_ID, {24'd0, next_id});
         write_register(REG_STAGE_TICKS, {16'd0, next_ticks});
         // Long stages would stall the parser for the rest of the phase: no tests then.
         tests_allowed = (unit_ticks <= 16'd8);
         // Vary the idling; the last phase runs flat out on both sides.
         sender_gaps = (phase != PHASES - 1) && (phase % 3 != 1);
         rsp_gaps   <= (phase != PHASES - 1) && (phase % 3 != 2);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: loose bytes and ticks, broken frames
               repeat ($urandom_range(1, 6))
                  push_event(1'($urandom_range(0, 1)), pick_byte());
            end else begin
               send_random_frame(tests_allowed);
            end
            if ($urandom_range(0, 29) == 0)
               wait_for_results();
         end
         // Drain any lamp test still running before the next setting lands.
         if (tests_allowed)
            send_ticks(TEST_STAGES_DEFAULT * int'(unit_ticks) + 1);
      end

      wait_for_results();
      repeat (4) @(posedge clock);

      $display("Ran %0d byte and tick transactions over %0d register settings;",
               items_sent, PHASES + 1);
      $display("%0d results checked, covering frames, broadcast, lamp tests and noise.",
               results_checked);
      if (failures == 0 && outstanding == 0)
         $display("** serial_command_relay_led_controller: PASSED **");
      else
         $display("** serial_command_relay_led_controller: FAILED **");
      $finish;
   end

endmodule

// File: filelist.f
hdl/scrlc_pkg.sv
hdl/scrlc_engine.sv
hdl/scrlc_out_buf.sv
hdl/serial_command_relay_led_controller.sv
hdl/scrlc_checker.sv
dv/scrlc_relay_checker.sv
dv/tb_serial_command_relay_led_controller.sv
